[hw/rtl/kmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants of the key matrix debounce layer block.
// ----------------------------------------------------------------------------
package kmd_pkg;

    // Field widths of the sample and event words.
    localparam int ROW_W   = 3;
    localparam int COL_W   = 4;
    localparam int COUNT_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_KEY_ROW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_KEY_COL  = 2'd2;

    localparam logic [COUNT_W-1:0] LOCKOUT_LENGTH_RESET = 16'd200;
    localparam logic [ROW_W-1:0]   LAYER_KEY_ROW_RESET  = 3'd3;
    localparam logic [COL_W-1:0]   LAYER_KEY_COL_RESET  = 4'd10;

    // Queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_WAIT_PRESS,
        PH_PRESS_LOCK,
        PH_WAIT_RELEASE,
        PH_RELEASE_LOCK
    } kmd_phase_t;

    // One in-range sample as it travels through the queue.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             pressed;
    } kmd_item_t;

    // Per-key state held in the key memory.
    typedef struct packed {
        kmd_phase_t         phase;
        logic [COUNT_W-1:0] count;
    } kmd_entry_t;

    // Configuration seen by the back part.
    typedef struct packed {
        logic [COUNT_W-1:0] lockout_length;
        logic [ROW_W-1:0]   layer_key_row;
        logic [COL_W-1:0]   layer_key_col;
    } kmd_cfg_t;

endpackage

[hw/rtl/kmd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_front
// Accepts sample words and passes only those that lie inside the matrix.
// ----------------------------------------------------------------------------
module kmd_front #(
    parameter int ROWS = 5,
    parameter int COLS = 11
) (
    input  logic                    key_valid,
    output logic                    key_stall,
    input  logic [kmd_pkg::ROW_W-1:0] key_row,
    input  logic [kmd_pkg::COL_W-1:0] key_col,
    input  logic                    key_pressed,
    input  logic                    q_full,
    output logic                    q_push,
    output kmd_pkg::kmd_item_t      q_item
);

    logic in_range;

    // Samples outside the matrix are accepted and dropped here.
    assign in_range  = (32'(key_row) < ROWS) && (32'(key_col) < COLS);
    assign key_stall = q_full;
    assign q_push    = key_valid && !q_full && in_range;

    always_comb
    begin
        q_item.row     = key_row;
        q_item.col     = key_col;
        q_item.pressed = key_pressed;
    end

endmodule

[hw/rtl/kmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_queue
// Short first-in first-out queue of sample words between front and back.
// ----------------------------------------------------------------------------
module kmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  kmd_pkg::kmd_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output kmd_pkg::kmd_item_t head_item
);

    localparam int PTR_W = (kmd_pkg::QUEUE_DEPTH > 1) ? $clog2(kmd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(kmd_pkg::QUEUE_DEPTH + 1);

    kmd_pkg::kmd_item_t slot_reg [kmd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (32'(p) == kmd_pkg::QUEUE_DEPTH - 1)
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign full       = (32'(fill_reg) == kmd_pkg::QUEUE_DEPTH);
    assign head_valid = (fill_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[hw/rtl/kmd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_back
// Per-key lockout state machine, layer flag and event output register.
// ----------------------------------------------------------------------------
module kmd_back #(
    parameter int ROWS = 5,
    parameter int COLS = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kmd_pkg::kmd_cfg_t         cfg,
    input  logic                      q_valid,
    input  kmd_pkg::kmd_item_t        q_item,
    output logic                      q_pop,
    output logic                      event_valid,
    input  logic                      event_stall,
    output logic [kmd_pkg::ROW_W-1:0] event_row,
    output logic [kmd_pkg::COL_W-1:0] event_col,
    output logic                      event_layer,
    output logic                      event_press
);

    localparam int NKEYS = ROWS * COLS;
    localparam int KEY_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

    // Key memory with registered read data and one valid bit per key.
    kmd_pkg::kmd_entry_t mem [NKEYS];
    kmd_pkg::kmd_entry_t rd_reg;
    logic [NKEYS-1:0]    valid_reg;

    // Read stage to update stage.
    logic               b_valid_reg;
    kmd_pkg::kmd_item_t b_item_reg;
    logic [KEY_W-1:0]   b_key_reg;

    // Last write, forwarded when the next sample hits the same key.
    logic                last_wr_valid_reg;
    logic [KEY_W-1:0]    last_wr_key_reg;
    kmd_pkg::kmd_entry_t last_wr_data_reg;

    logic active_layer_reg;

    logic                      event_valid_reg;
    logic [kmd_pkg::ROW_W-1:0] event_row_reg;
    logic [kmd_pkg::COL_W-1:0] event_col_reg;
    logic                      event_layer_reg;
    logic                      event_press_reg;

    logic                a_fire;
    logic                b_fire;
    logic [KEY_W-1:0]    a_key;
    kmd_pkg::kmd_entry_t cur;
    kmd_pkg::kmd_entry_t upd;
    logic                timeout;
    logic                ev;
    logic                is_layer_key;
    logic                emit;

    assign a_key  = KEY_W'(32'(q_item.row) * COLS + 32'(q_item.col));
    assign b_fire = b_valid_reg && (!event_valid_reg || !event_stall);
    assign a_fire = q_valid && (!b_valid_reg || b_fire);
    assign q_pop  = a_fire;

    always_comb
    begin
        if (!valid_reg[b_key_reg])
            cur = '0;
        else if (last_wr_valid_reg && (last_wr_key_reg == b_key_reg))
            cur = last_wr_data_reg;
        else
            cur = rd_reg;

        timeout   = (cur.count == kmd_pkg::COUNT_W'(1));
        ev        = 1'b0;
        upd.phase = cur.phase;
        unique case (cur.phase)
            kmd_pkg::PH_WAIT_PRESS:
            begin
                if (b_item_reg.pressed)
                begin
                    ev        = 1'b1;
                    upd.phase = kmd_pkg::PH_PRESS_LOCK;
                end
            end
            kmd_pkg::PH_PRESS_LOCK:
            begin
                if (timeout)
                    upd.phase = kmd_pkg::PH_WAIT_RELEASE;
            end
            kmd_pkg::PH_WAIT_RELEASE:
            begin
                if (!b_item_reg.pressed)
                begin
                    ev        = 1'b1;
                    upd.phase = kmd_pkg::PH_RELEASE_LOCK;
                end
            end
            kmd_pkg::PH_RELEASE_LOCK:
            begin
                if (timeout)
                    upd.phase = kmd_pkg::PH_WAIT_PRESS;
            end
        endcase

        if (ev)
            upd.count = cfg.lockout_length;
        else if (cur.count != '0)
            upd.count = cur.count - kmd_pkg::COUNT_W'(1);
        else
            upd.count = cur.count;

        is_layer_key = (b_item_reg.row == cfg.layer_key_row) &&
                       (b_item_reg.col == cfg.layer_key_col);
        emit = ev && !is_layer_key;
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
            rd_reg <= mem[a_key];
        if (b_fire)
            mem[b_key_reg] <= upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            b_valid_reg       <= 1'b0;
            last_wr_valid_reg <= 1'b0;
            active_layer_reg  <= 1'b0;
            event_valid_reg   <= 1'b0;
        end
        else
        begin
            if (a_fire)
                b_valid_reg <= 1'b1;
            else if (b_fire)
                b_valid_reg <= 1'b0;

            if (b_fire)
            begin
                valid_reg[b_key_reg] <= 1'b1;
                last_wr_valid_reg    <= 1'b1;
                if (ev && is_layer_key)
                    active_layer_reg <= b_item_reg.pressed;
            end

            if (b_fire && emit)
                event_valid_reg <= 1'b1;
            else if (!event_stall)
                event_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_item_reg <= q_item;
            b_key_reg  <= a_key;
        end
        if (b_fire)
        begin
            last_wr_key_reg  <= b_key_reg;
            last_wr_data_reg <= upd;
        end
        if (b_fire && emit)
        begin
            event_row_reg   <= b_item_reg.row;
            event_col_reg   <= b_item_reg.col;
            event_layer_reg <= active_layer_reg;
            event_press_reg <= b_item_reg.pressed;
        end
    end

    assign event_valid = event_valid_reg;
    assign event_row   = event_row_reg;
    assign event_col   = event_col_reg;
    assign event_layer = event_layer_reg;
    assign event_press = event_press_reg;

endmodule

[hw/rtl/key_matrix_debounce_layer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_layer
// Lockout debounce of scanned key samples with a layer-change key.
// ----------------------------------------------------------------------------
// An event word passes from the queue slot through the read stage register
// to the event output register. Throughput: one sample word per cycle
// unless the event output stalls, set by separate read and write ports of
// the key memory, with the last write forwarded to the next sample.
// Reset: rst_n clears all key phases and counters at once through per-key
// valid bits; no clearing pass. Layer flag and registers return to defaults.
// ----------------------------------------------------------------------------
module key_matrix_debounce_layer #(
    parameter int ROWS = 5,
    parameter int COLS = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           key_valid,
    output logic                           key_stall,
    input  logic [kmd_pkg::ROW_W-1:0]      key_row,
    input  logic [kmd_pkg::COL_W-1:0]      key_col,
    input  logic                           key_pressed,
    output logic                           event_valid,
    input  logic                           event_stall,
    output logic [kmd_pkg::ROW_W-1:0]      event_row,
    output logic [kmd_pkg::COL_W-1:0]      event_col,
    output logic                           event_layer,
    output logic                           event_press
);

    // Configuration registers. Writes to an index past the list are ignored.
    kmd_pkg::kmd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_length <= kmd_pkg::LOCKOUT_LENGTH_RESET;
            cfg_reg.layer_key_row  <= kmd_pkg::LAYER_KEY_ROW_RESET;
            cfg_reg.layer_key_col  <= kmd_pkg::LAYER_KEY_COL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == kmd_pkg::CFG_LOCKOUT_LENGTH)
                cfg_reg.lockout_length <= cfg_data;
            else if (cfg_index == kmd_pkg::CFG_LAYER_KEY_ROW)
                cfg_reg.layer_key_row <= cfg_data[kmd_pkg::ROW_W-1:0];
            else if (cfg_index == kmd_pkg::CFG_LAYER_KEY_COL)
                cfg_reg.layer_key_col <= cfg_data[kmd_pkg::COL_W-1:0];
        end
    end

    // The front part takes a sample word whenever the queue has room and
    // drops words whose position lies outside the matrix.
    logic               q_full;
    logic               q_push;
    kmd_pkg::kmd_item_t q_push_item;
    logic               q_pop;
    logic               q_head_valid;
    kmd_pkg::kmd_item_t q_head_item;

    kmd_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .key_valid   (key_valid),
        .key_stall   (key_stall),
        .key_row     (key_row),
        .key_col     (key_col),
        .key_pressed (key_pressed),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    // The queue lets the front keep taking words while the event output
    // is stalled, up to its depth.
    kmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    // The back part reads the key's state into the read stage register, then
    // updates and writes it back, and loads the event output register when an
    // event is produced. A press or release of the layer key only moves the flag.
    kmd_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_head_valid),
        .q_item      (q_head_item),
        .q_pop       (q_pop),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_row   (event_row),
        .event_col   (event_col),
        .event_layer (event_layer),
        .event_press (event_press)
    );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key matrix debounce layer block.
// ----------------------------------------------------------------------------
// Scanned key samples are sent with random gaps while the event side is
// stalled at random. Every accepted sample goes through a local copy of the
// per-key lockout machines, and the event it should cause is queued. Events
// leaving the block are checked in order against that queue. A short
// directed table comes first. Random phases follow, each with its own
// lockout length and layer key position.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ROWS           = 5;
    localparam int COLS           = 11;
    localparam int KEYS           = ROWS * COLS;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TABLE_LEN      = 28;
    localparam int PHASES         = 7;

    typedef logic [kmd_pkg::ROW_W-1:0]      row_t;
    typedef logic [kmd_pkg::COL_W-1:0]      col_t;
    typedef logic [kmd_pkg::COUNT_W-1:0]    count_t;
    typedef logic [kmd_pkg::CFG_IDX_W-1:0]  reg_idx_t;
    typedef logic [kmd_pkg::CFG_DATA_W-1:0] reg_data_t;

    localparam reg_idx_t REG_LEN  = kmd_pkg::CFG_LOCKOUT_LENGTH;
    localparam reg_idx_t REG_LROW = kmd_pkg::CFG_LAYER_KEY_ROW;
    localparam reg_idx_t REG_LCOL = kmd_pkg::CFG_LAYER_KEY_COL;

    // How a directed row is checked: against the predictor, against no event
    // at all, or against the event written into the row.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_EVENT
    } check_t;

    typedef enum logic {
        STEP_SAMPLE,
        STEP_WRITE
    } step_kind_t;

    typedef struct {
        step_kind_t kind;
        reg_idx_t   reg_index;
        reg_data_t  reg_data;
        row_t       row;
        col_t       col;
        logic       pressed;
        check_t     check;
        logic       exp_layer;
        logic       exp_press;
    } step_t;

    typedef struct packed {
        row_t row;
        col_t col;
        logic layer;
        logic press;
    } key_event_t;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      cfg_we      = 1'b0;
    reg_idx_t  cfg_index   = REG_LEN;
    reg_data_t cfg_data    = '0;
    logic      key_valid   = 1'b0;
    logic      key_stall;
    row_t      key_row     = '0;
    col_t      key_col     = '0;
    logic      key_pressed = 1'b0;
    logic      event_valid;
    logic      event_stall = 1'b0;
    row_t      event_row;
    col_t      event_col;
    logic      event_layer;
    logic      event_press;

    // Local copy of the block's state and registers.
    kmd_pkg::kmd_phase_t key_phase [KEYS];
    count_t              lockout_left [KEYS];
    logic                layer_on;
    count_t              lock_len;
    row_t                lyr_key_row;
    col_t                lyr_key_col;

    // Events still owed by the block, oldest first.
    key_event_t pending_events [$];

    step_t directed_steps [TABLE_LEN];

    // Random phase settings. The fourth lockout length and layer key are
    // drawn at run time; the zero lockout phase comes last because it
    // freezes every key that fires.
    count_t phase_lockout [PHASES] =
        '{16'd1, 16'd2, 16'd3, 16'd5, 16'd4, 16'd65535, 16'd0};
    row_t   phase_layer_row [PHASES] = '{3'd3, 3'd0, 3'd4, 3'd0, 3'd5, 3'd7, 3'd2};
    col_t   phase_layer_col [PHASES] =
        '{4'd10, 4'd0, 4'd10, 4'd0, 4'd3, 4'd15, 4'd2};
    int     phase_items [PHASES] = '{300, 300, 300, 300, 300, 250, 250};

    int  errors          = 0;
    int  samples_sent    = 0;
    int  ignored_samples = 0;
    int  events_checked  = 0;
    int  register_writes = 0;
    int  stall_left      = 0;
    int  idle_cycles     = 0;
    bit  steady          = 1'b0;

    key_matrix_debounce_layer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .key_valid(key_valid),
        .key_stall(key_stall),
        .key_row(key_row),
        .key_col(key_col),
        .key_pressed(key_pressed),
        .event_valid(event_valid),
        .event_stall(event_stall),
        .event_row(event_row),
        .event_col(event_col),
        .event_layer(event_layer),
        .event_press(event_press)
    );

    always #5 clk = ~clk;

    // Length of an idle stretch: mostly none, often short, now and
    // then a long one. A steady stretch turns idling off on both sides.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Advances the local key machines by one sample and reports the event,
    // if any, that the sample should produce.
    function automatic void debounce_sample(input row_t row,
                                            input col_t col,
                                            input logic pressed,
                                            output bit produced,
                                            output key_event_t ev);
        int k;
        kmd_pkg::kmd_phase_t ph;
        count_t cnt;
        bit expired;
        bit fired;
        bit is_press;
        produced = 1'b0;
        ev       = '0;
        fired    = 1'b0;
        is_press = 1'b0;
        // Samples from outside the matrix leave everything untouched.
        if (row >= ROWS || col >= COLS)
        begin
            ignored_samples++;
            return;
        end
        k       = row * COLS + col;
        ph      = key_phase[k];
        cnt     = lockout_left[k];
        expired = (cnt == 1);
        case (ph)
            kmd_pkg::PH_WAIT_PRESS:
                if (pressed)
                begin
                    fired    = 1'b1;
                    is_press = 1'b1;
                    ph       = kmd_pkg::PH_PRESS_LOCK;
                end
            kmd_pkg::PH_PRESS_LOCK:
                if (expired)
                    ph = kmd_pkg::PH_WAIT_RELEASE;
            // A key still held in wait release just stays there.
            kmd_pkg::PH_WAIT_RELEASE:
                if (!pressed)
                begin
                    fired = 1'b1;
                    ph    = kmd_pkg::PH_RELEASE_LOCK;
                end
            default:
                if (expired)
                    ph = kmd_pkg::PH_WAIT_PRESS;
        endcase
        key_phase[k] = ph;
        // A fresh load takes priority over the countdown.
        if (fired)
            lockout_left[k] = lock_len;
        else if (cnt != 0)
            lockout_left[k] = cnt - 1'b1;
        if (fired)
        begin
            if (row == lyr_key_row && col == lyr_key_col)
            begin
                layer_on = is_press;
            end
            else
            begin
                produced = 1'b1;
                ev.row   = row;
                ev.col   = col;
                ev.layer = layer_on;
                ev.press = is_press;
            end
        end
    endfunction

    // Presents one sample word, holds it until accepted and records what it
    // should cause. The valid stays high when the next word follows at once.
    task automatic send_sample(input row_t row,
                               input col_t col,
                               input logic pressed,
                               input check_t check,
                               input logic exp_layer,
                               input logic exp_press);
        int gap;
        bit produced;
        key_event_t predicted;
        key_event_t typed;
        gap = idle_length();
        if (gap > 0)
        begin
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_valid   <= 1'b1;
        key_row     <= row;
        key_col     <= col;
        key_pressed <= pressed;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        samples_sent++;
        debounce_sample(row, col, pressed, produced, predicted);
        case (check)
            CHK_MODEL:
                if (produced)
                    pending_events.push_back(predicted);
            CHK_EVENT:
            begin
                typed.row   = row;
                typed.col   = col;
                typed.layer = exp_layer;
                typed.press = exp_press;
                pending_events.push_back(typed);
            end
            default: ;
        endcase
    endtask

    // Stops sending, waits for every owed event, then lets the pipeline run
    // dry, since samples that produce nothing may still be in flight.
    task automatic drain();
        key_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t index,
                                  input reg_data_t value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        register_writes++;
        case (index)
            REG_LEN:  lock_len    = value;
            REG_LROW: lyr_key_row = value[kmd_pkg::ROW_W-1:0];
            REG_LCOL: lyr_key_col = value[kmd_pkg::COL_W-1:0];
            default: ;
        endcase
    endtask

    // Event side back-pressure.
    always @(posedge clk)
    begin
        if (stall_left == 0)
            stall_left = idle_length();
        if (stall_left > 0)
        begin
            event_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            event_stall <= 1'b0;
        end
    end

    // Every event word leaving the block must match the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && event_valid && !event_stall)
        begin
            events_checked++;
            if (pending_events.size() == 0)
            begin
                flag_error($sformatf("unexpected event row %0d col %0d layer %0d press %0d",
                                     event_row, event_col, event_layer, event_press));
            end
            else
            begin
                if (event_row   != pending_events[0].row   ||
                    event_col   != pending_events[0].col   ||
                    event_layer != pending_events[0].layer ||
                    event_press != pending_events[0].press)
                    flag_error($sformatf({"event mismatch: expected row %0d col %0d ",
                                          "layer %0d press %0d, got row %0d col %0d ",
                                          "layer %0d press %0d"},
                                         pending_events[0].row, pending_events[0].col,
                                         pending_events[0].layer, pending_events[0].press,
                                         event_row, event_col, event_layer, event_press));
                void'(pending_events.pop_front());
            end
        end
    end

    // Ends a run that has stopped moving words in either direction.
    always @(posedge clk)
    begin
        if ((key_valid && !key_stall) || (event_valid && !event_stall))
        begin
            idle_cycles = 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles, %0d events still owed",
                     idle_cycles, pending_events.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles++;
        end
    end

    initial
    begin : stimulus
        row_t hot_row [4];
        col_t hot_col [4];
        logic hot_held [4];
        logic level;
        int   h;
        int   r;

        for (int k = 0; k < KEYS; k++)
        begin
            key_phase[k]    = kmd_pkg::PH_WAIT_PRESS;
            lockout_left[k] = '0;
        end
        layer_on    = 1'b0;
        lock_len    = kmd_pkg::LOCKOUT_LENGTH_RESET;
        lyr_key_row = kmd_pkg::LAYER_KEY_ROW_RESET;
        lyr_key_col = kmd_pkg::LAYER_KEY_COL_RESET;

        // Directed part. The first rows run with the reset settings, so their
        // events can be written down directly. Later rows shorten the lockout
        // to walk one key through its whole cycle, move the layer key onto a
        // fresh key, and finally push it outside the matrix.
        directed_steps = '{
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd0,  1'b1, CHK_EVENT, 1'b0, 1'b1},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd0,  1'b0, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd4, 4'd10, 1'b1, CHK_EVENT, 1'b0, 1'b1},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd7, 4'd15, 1'b1, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd5, 4'd0,  1'b1, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd11, 1'b1, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd3, 4'd10, 1'b1, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd2, 4'd5,  1'b1, CHK_EVENT, 1'b1, 1'b1},
            '{STEP_WRITE,  REG_LEN,  16'd1, 3'd0, 4'd0,  1'b0, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd1, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd1, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd1, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd1, 4'd1,  1'b0, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd1, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd1, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_WRITE,  REG_LEN,  16'd2, 3'd0, 4'd0,  1'b0, CHK_NONE,  1'b0, 1'b0},
            '{STEP_WRITE,  REG_LROW, 16'd0, 3'd0, 4'd0,  1'b0, CHK_NONE,  1'b0, 1'b0},
            '{STEP_WRITE,  REG_LCOL, 16'd1, 3'd0, 4'd0,  1'b0, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd1,  1'b1, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd1,  1'b0, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd2, 4'd6,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd4, 4'd0,  1'b0, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_WRITE,  REG_LROW, 16'd7, 3'd0, 4'd0,  1'b0, CHK_NONE,  1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0},
            '{STEP_SAMPLE, REG_LEN,  16'd0, 3'd0, 4'd1,  1'b1, CHK_MODEL, 1'b0, 1'b0}
        };

        phase_lockout[3]   = count_t'($urandom_range(1, 6));
        phase_layer_row[3] = row_t'($urandom_range(0, 4));
        phase_layer_col[3] = col_t'($urandom_range(0, 10));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int s = 0; s < TABLE_LEN; s++)
        begin
            if (directed_steps[s].kind == STEP_WRITE)
                write_register(directed_steps[s].reg_index, directed_steps[s].reg_data);
            else
                send_sample(directed_steps[s].row, directed_steps[s].col,
                            directed_steps[s].pressed, directed_steps[s].check,
                            directed_steps[s].exp_layer, directed_steps[s].exp_press);
        end

        // Random phases. Most samples come from a few hot keys that are held
        // and released like real keys, with the odd contact bounce, so the
        // lockouts actually run out. The layer key is one of them when it
        // lies inside the matrix. The rest is noise over the full field range,
        // positions outside the matrix included.
        for (int p = 0; p < PHASES; p++)
        begin
            write_register(REG_LEN, phase_lockout[p]);
            write_register(REG_LROW, reg_data_t'(phase_layer_row[p]));
            write_register(REG_LCOL, reg_data_t'(phase_layer_col[p]));
            for (int j = 0; j < 4; j++)
            begin
                hot_row[j]  = row_t'($urandom_range(0, ROWS - 1));
                hot_col[j]  = col_t'($urandom_range(0, COLS - 1));
                hot_held[j] = 1'b0;
            end
            if (lyr_key_row < ROWS && lyr_key_col < COLS)
            begin
                hot_row[0] = lyr_key_row;
                hot_col[0] = lyr_key_col;
            end
            for (int i = 0; i < phase_items[p]; i++)
            begin
                steady = (i % 100) < 25;
                // Swap one hot key now and then so many keys get visited.
                if (i % 60 == 59)
                begin
                    h          = $urandom_range(1, 3);
                    hot_row[h] = row_t'($urandom_range(0, ROWS - 1));
                    hot_col[h] = col_t'($urandom_range(0, COLS - 1));
                end
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    h = $urandom_range(0, 3);
                    if ($urandom_range(0, 4) == 0)
                        hot_held[h] = ~hot_held[h];
                    level = hot_held[h];
                    if ($urandom_range(0, 9) == 0)
                        level = ~level;
                    send_sample(hot_row[h], hot_col[h], level, CHK_MODEL, 1'b0, 1'b0);
                end
                else
                begin
                    send_sample(row_t'($urandom_range(0, 7)), col_t'($urandom_range(0, 15)),
                                1'($urandom_range(0, 1)), CHK_MODEL, 1'b0, 1'b0);
                end
            end
            steady = 1'b0;
        end

        drain();
        if (pending_events.size() != 0)
            flag_error($sformatf("%0d events never arrived", pending_events.size()));

        $display("Sent %0d sample words (%0d outside the matrix), checked %0d event words,",
                 samples_sent, ignored_samples, events_checked);
        $display("made %0d register writes over %0d random phases, %0d errors.",
                 register_writes, PHASES, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kmd_pkg.sv
hw/rtl/kmd_front.sv
hw/rtl/kmd_queue.sv
hw/rtl/kmd_back.sv
hw/rtl/key_matrix_debounce_layer.sv
bench/testbench.sv
